[rtl/core/ica_pkg.sv]
// shared types, constants and codes of the instruction and call accounting block
package ica_pkg;

   localparam int HISTOGRAM_ENTRIES = 512;
   localparam int HIST_AW = $clog2(HISTOGRAM_ENTRIES);
   localparam logic [HIST_AW-1:0] HIST_LAST = HIST_AW'(HISTOGRAM_ENTRIES - 1);

   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALL_COST   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_OFFS  = 3'd4;

   // start modes
   localparam logic [1:0] START_IMMEDIATE = 2'd0;
   localparam logic [1:0] START_RELATIVE  = 2'd2;

   // event codes
   localparam logic [1:0] OP_BLOCK  = 2'd0;
   localparam logic [1:0] OP_ENTRY  = 2'd1;
   localparam logic [1:0] OP_RETURN = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   // call numbers with side tracking
   localparam logic signed [15:0] CALL_MAP   = 16'sd9;
   localparam logic signed [15:0] CALL_UNMAP = 16'sd11;
   localparam logic signed [15:0] CALL_BREAK = 16'sd12;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [63:0]        block_address;
      logic [63:0]        block_end_address;
      logic [12:0]        block_instructions;
      logic signed [15:0] call_number;
      logic [63:0]        map_length;
      logic signed [63:0] return_value;
      logic [8:0]         histogram_index;
   } ica_req_type;

   typedef struct packed {
      logic [63:0] instructions_total;
      logic        limit_hit;
      logic        counting_active;
      logic [63:0] calls_total;
      logic [63:0] mapped_bytes;
      logic [63:0] mapped_peak;
      logic [63:0] heap_growth;
      logic [63:0] histogram_count;
   } ica_rsp_type;

   typedef struct packed {
      logic               en;
      logic [HIST_AW-1:0] addr;
      logic [63:0]        data;
   } ica_hist_wr_type;

endpackage

[rtl/core/ica_req_if.sv]
// event channel: valid, ready and one event
interface ica_req_if
   import ica_pkg::*;
();
   logic        valid;
   logic        ready;
   ica_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/ica_rsp_if.sv]
// result channel: valid, ready and one result
interface ica_rsp_if
   import ica_pkg::*;
();
   logic        valid;
   logic        ready;
   ica_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/ica_hist.sv]
// per-call-number histogram memory with clearing sweep and write forwarding
module ica_hist
   import ica_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [HIST_AW-1:0] rd_addr,
   input  ica_hist_wr_type    wr,
   output logic [63:0]        rd_data,
   output logic               busy
);

   logic [63:0]        mem [HISTOGRAM_ENTRIES];
   logic [63:0]        rdata_ff;
   logic [63:0]        fwd_data_ff;
   logic               fwd_hit_ff;
   logic               clr_active_ff;
   logic [HIST_AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff    <= mem[rd_addr];
         fwd_data_ff <= wr.data;
      end
   end

   // a read issued on the edge of a write to the same entry sees the new word, forwarded
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff    <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         if (rd_en) begin
            fwd_hit_ff <= wr.en && (wr.addr == rd_addr);
         end
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == HIST_LAST) begin
               clr_active_ff <= 1'b0;
            end
         end
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rdata_ff;
   assign busy    = clr_active_ff;

endmodule

[rtl/core/instruction_and_syscall_accounting.sv]
// top level of the instruction and system call accounting monitor
//
//   channel   direction  transfer when           carries
//   req_ch    in         valid && ready         one event (block, call, return, read)
//   rsp_ch    out        valid && ready         one result per event
//   csr_*     in         csr_we                 register write, no read-back
//
// one event per cycle while results are taken and the histogram is not clearing;
// a result passes the working stage, then the output register; the pace is set
// by the histogram read-modify-write: one read port, one write port, the word
// written on the same edge as a read is forwarded; after reset a clearing sweep
// zeroes all 512 histogram entries with req ready low; a stalled result holds in
// the output register while one more event waits in the working stage
module instruction_and_syscall_accounting
   import ica_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   ica_req_if.sink              req_ch,
   ica_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   // configuration registers
   logic [63:0] budget_ff;
   logic [63:0] cost_ff;
   logic [1:0]  mode_ff;
   logic [63:0] soffs_ff;
   logic [63:0] eoffs_ff;

   // accounting state
   logic [63:0] instr_ff,      instr_in;
   logic        limit_ff,      limit_in;
   logic        counting_ff,   counting_in;
   logic        awaiting_ff,   awaiting_in;
   logic [63:0] start_ff,      start_in;
   logic [63:0] calls_ff,      calls_in;
   logic [63:0] mapped_ff,     mapped_in;
   logic [63:0] peak_ff,       peak_in;
   logic [63:0] brk_first_ff,  brk_first_in;
   logic [63:0] brk_latest_ff, brk_latest_in;
   logic        brk_seen_ff,   brk_seen_in;

   // working stage, loaded on each input transfer
   logic               s1_valid_ff;
   logic [1:0]         s1_op_ff;
   logic [63:0]        s1_baddr_ff;
   logic [63:0]        s1_bend_ff;
   logic               s1_bend_gt_ff;
   logic [63:0]        s1_cand_ff;
   logic [12:0]        s1_binsn_ff;
   logic signed [15:0] s1_num_ff;
   logic [63:0]        s1_len_ff;
   logic [63:0]        s1_ret_ff;
   logic               s1_hit_ff;
   logic [HIST_AW-1:0] s1_addr_ff;

   // output register
   logic        rsp_valid_ff;
   ica_rsp_type rsp_payload_ff;

   logic               req_xfer;
   logic               s1_go;
   logic               hist_busy;
   logic [63:0]        hist_rd;
   ica_hist_wr_type    hist_wr;
   logic               hist_wr_en;
   logic [HIST_AW-1:0] rd_addr;
   logic               rd_hit;
   logic               num_hit;
   logic               idx_hit;

   logic [63:0] start_sel;
   logic        covers;
   logic        add_en;
   logic [63:0] add_val;
   logic [63:0] sum;
   logic [63:0] map_sum;
   logic [63:0] hcount;
   logic [63:0] growth;
   logic        ret_positive;

   logic [1:0]  mode_new;
   logic [63:0] soffs_new;

   // handshake: the working stage empties when the output register can take it
   assign s1_go        = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !hist_busy && (!s1_valid_ff || s1_go);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // histogram address: the call number on entries, the index on reads
   assign num_hit = !req_ch.payload.call_number[15] &&
                    (32'(req_ch.payload.call_number[14:0]) < HISTOGRAM_ENTRIES);
   assign idx_hit = 32'(req_ch.payload.histogram_index) < HISTOGRAM_ENTRIES;

   always_comb begin
      if (req_ch.payload.opcode == OP_READ) begin
         rd_addr = HIST_AW'(req_ch.payload.histogram_index);
         rd_hit  = idx_hit;
      end else begin
         rd_addr = HIST_AW'(req_ch.payload.call_number[14:0]);
         rd_hit  = num_hit;
      end
   end

   ica_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_addr (rd_addr),
      .wr      (hist_wr),
      .rd_data (hist_rd),
      .busy    (hist_busy)
   );

   // working stage; the relative start candidate is formed on the way in
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff      <= req_ch.payload.opcode;
         s1_baddr_ff   <= req_ch.payload.block_address;
         s1_bend_ff    <= req_ch.payload.block_end_address;
         s1_bend_gt_ff <= req_ch.payload.block_end_address > req_ch.payload.block_address;
         s1_cand_ff    <= req_ch.payload.block_address - eoffs_ff + soffs_ff;
         s1_binsn_ff   <= req_ch.payload.block_instructions;
         s1_num_ff     <= req_ch.payload.call_number;
         s1_len_ff     <= req_ch.payload.map_length;
         s1_ret_ff     <= req_ch.payload.return_value;
         s1_hit_ff     <= rd_hit;
         s1_addr_ff    <= rd_addr;
      end
   end

   // event evaluation against the current state
   always_comb begin
      instr_in      = instr_ff;
      limit_in      = limit_ff;
      counting_in   = counting_ff;
      awaiting_in   = awaiting_ff;
      start_in      = start_ff;
      calls_in      = calls_ff;
      mapped_in     = mapped_ff;
      peak_in       = peak_ff;
      brk_first_in  = brk_first_ff;
      brk_latest_in = brk_latest_ff;
      brk_seen_in   = brk_seen_ff;
      hcount        = '0;
      hist_wr_en    = 1'b0;
      add_en        = 1'b0;
      add_val       = '0;

      // the whole block counts once it holds the start address
      start_sel    = awaiting_ff ? s1_cand_ff : start_ff;
      covers       = s1_bend_gt_ff && (start_sel >= s1_baddr_ff) && (start_sel < s1_bend_ff);
      map_sum      = mapped_ff + s1_len_ff;
      ret_positive = !s1_ret_ff[63] && (s1_ret_ff != '0);

      if (s1_op_ff == OP_READ) begin
         hcount = s1_hit_ff ? hist_rd : '0;
      end else if (!limit_ff) begin
         unique case (s1_op_ff)
            OP_BLOCK: begin
               // first block fixes the load base
               if (awaiting_ff) begin
                  start_in    = s1_cand_ff;
                  awaiting_in = 1'b0;
               end
               if (counting_ff || covers) begin
                  counting_in = 1'b1;
                  add_en      = 1'b1;
                  add_val     = 64'(s1_binsn_ff);
               end
            end
            OP_ENTRY: begin
               if (counting_ff) begin
                  calls_in   = calls_ff + 64'd1;
                  hist_wr_en = s1_hit_ff;
                  if (s1_num_ff == CALL_MAP) begin
                     mapped_in = map_sum;
                     if (map_sum > peak_ff) begin
                        peak_in = map_sum;
                     end
                  end else if (s1_num_ff == CALL_UNMAP) begin
                     // unmap floors at zero
                     mapped_in = (s1_len_ff <= mapped_ff) ? mapped_ff - s1_len_ff : '0;
                  end
                  if (cost_ff != '0) begin
                     add_en  = 1'b1;
                     add_val = cost_ff;
                  end
               end
            end
            OP_RETURN: begin
               // returns are tracked whether counting or not, until the limit is hit
               if ((s1_num_ff == CALL_BREAK) && ret_positive) begin
                  if (!brk_seen_ff) begin
                     brk_first_in = s1_ret_ff;
                     brk_seen_in  = 1'b1;
                  end
                  brk_latest_in = s1_ret_ff;
               end
            end
            default: begin
            end
         endcase
      end

      // budget check after each addition, sticky
      sum = instr_ff + add_val;
      if (add_en) begin
         instr_in = sum;
         if ((budget_ff != '0) && (sum >= budget_ff)) begin
            limit_in = 1'b1;
         end
      end

      growth = (brk_seen_in && (brk_latest_in > brk_first_in)) ?
               brk_latest_in - brk_first_in : '0;
   end

   assign hist_wr.en   = hist_wr_en && s1_go;
   assign hist_wr.addr = s1_addr_ff;
   assign hist_wr.data = hist_rd + 64'd1;

   // register writes that touch the start logic re-arm it from the new values
   assign mode_new  = (csr_index == CSR_START_MODE) ? csr_wdata[1:0] : mode_ff;
   assign soffs_new = (csr_index == CSR_START_OFFS) ? csr_wdata : soffs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff     <= '0;
         cost_ff       <= '0;
         mode_ff       <= START_IMMEDIATE;
         soffs_ff      <= '0;
         eoffs_ff      <= '0;
         instr_ff      <= '0;
         limit_ff      <= 1'b0;
         counting_ff   <= 1'b1;
         awaiting_ff   <= 1'b0;
         start_ff      <= '0;
         calls_ff      <= '0;
         mapped_ff     <= '0;
         peak_ff       <= '0;
         brk_first_ff  <= '0;
         brk_latest_ff <= '0;
         brk_seen_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (s1_go) begin
            instr_ff      <= instr_in;
            limit_ff      <= limit_in;
            counting_ff   <= counting_in;
            awaiting_ff   <= awaiting_in;
            start_ff      <= start_in;
            calls_ff      <= calls_in;
            mapped_ff     <= mapped_in;
            peak_ff       <= peak_in;
            brk_first_ff  <= brk_first_in;
            brk_latest_ff <= brk_latest_in;
            brk_seen_ff   <= brk_seen_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_BUDGET:     budget_ff <= csr_wdata;
               CSR_CALL_COST:  cost_ff   <= csr_wdata;
               CSR_START_MODE: mode_ff   <= csr_wdata[1:0];
               CSR_START_OFFS: soffs_ff  <= csr_wdata;
               CSR_ENTRY_OFFS: eoffs_ff  <= csr_wdata;
               default: begin
               end
            endcase
            if ((csr_index == CSR_START_MODE) || (csr_index == CSR_START_OFFS)) begin
               counting_ff <= (mode_new == START_IMMEDIATE);
               awaiting_ff <= (mode_new == START_RELATIVE);
               start_ff    <= soffs_new;
            end
         end
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result shows the state after the event
   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_payload_ff.instructions_total <= instr_in;
         rsp_payload_ff.limit_hit          <= limit_in;
         rsp_payload_ff.counting_active    <= counting_in;
         rsp_payload_ff.calls_total        <= calls_in;
         rsp_payload_ff.mapped_bytes       <= mapped_in;
         rsp_payload_ff.mapped_peak        <= peak_in;
         rsp_payload_ff.heap_growth        <= growth;
         rsp_payload_ff.histogram_count    <= hcount;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

endmodule

[rtl/core/ica_checker.sv]
// port-level checks of the accounting monitor and their binding
module ica_checker
   import ica_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input ica_rsp_type rsp_payload
);

   logic limit_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_payload.limit_hit) begin
         limit_seen_ff <= 1'b1;
      end
   end

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // limit stays once reported
   a_limit_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && limit_seen_ff |-> rsp_payload.limit_hit)
      else $error("limit flag dropped");

   // peak never below current mapped total
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.mapped_peak >= rsp_payload.mapped_bytes)
      else $error("mapped peak below mapped total");

   // histogram clearing keeps events out right after reset
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("event taken during histogram clear");

endmodule

bind instruction_and_syscall_accounting ica_checker u_ica_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
